// ----- src/glq_pkg.sv -----
package glq_pkg;

  // Table geometry and metric storage width
  localparam int GLYPH_SLOTS = 256;
  localparam int METRIC_BITS = 16;
  localparam int SLOT_W      = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

  // Fixed field widths
  localparam int CODE_W    = 8;
  localparam int SCALE_W   = 24;
  localparam int POS_W     = 32;
  localparam int TEX_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Arithmetic widths: metric sums, scale products, rounded offsets, pen sums
  localparam int EXT_W      = METRIC_BITS + 2;
  localparam int PROD_W     = EXT_W + SCALE_W + 1;
  localparam int FRAC_SHIFT = 12;
  localparam int ROUND_BIAS = 2048;
  localparam int OFF_W      = PROD_W - FRAC_SHIFT;
  localparam int SUM_W      = ((OFF_W > POS_W) ? OFF_W : POS_W) + 1;

  localparam logic [CODE_W-1:0]  CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0]  CODE_SPACE   = 8'd32;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd256;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_SCALE    = 3'd3,
    CFG_FLIP_Y   = 3'd4
  } cfg_reg_t;

  // What a pipelined item does once it reaches the pen
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_START   = 3'd1,
    KIND_NEWLINE = 3'd2,
    KIND_ADVANCE = 3'd3,
    KIND_GLYPH   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef struct packed {
    logic [TEX_W-1:0] bottom;
    logic [TEX_W-1:0] right;
    logic [TEX_W-1:0] top;
    logic [TEX_W-1:0] left;
  } tex_box_t;

  typedef struct packed {
    tex_box_t                tex;
    logic [METRIC_BITS-1:0]  step;
    logic [METRIC_BITS-1:0]  hgt;
    logic [METRIC_BITS-1:0]  wid;
    logic signed [METRIC_BITS-1:0] yoff;
    logic signed [METRIC_BITS-1:0] xoff;
  } glyph_entry_t;

  // Scaled offsets in Q.8, vertical ones already flipped when flip_y is set
  typedef struct packed {
    kind_t                   kind;
    tex_box_t                tex;
    logic signed [OFF_W-1:0] d_step;
    logic signed [OFF_W-1:0] dy_b;
    logic signed [OFF_W-1:0] dy_t;
    logic signed [OFF_W-1:0] dx_r;
    logic signed [OFF_W-1:0] dx_l;
  } off_t;

  // Round a Q.20 product to Q.8: add half, then floor
  function automatic logic signed [OFF_W-1:0] round_q8(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + PROD_W'(ROUND_BIAS);
    return s[PROD_W-1:FRAC_SHIFT];
  endfunction

  // Clamp a wide sum to the signed position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'($signed({1'b0, {(POS_W-1){1'b1}}}));
    lo = SUM_W'($signed({1'b1, {(POS_W-1){1'b0}}}));
    if (v > hi) begin
      return hi[POS_W-1:0];
    end else if (v < lo) begin
      return lo[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] add_pos(input logic signed [POS_W-1:0] pen,
                                                      input logic signed [OFF_W-1:0] off);
    return sat_pos(SUM_W'(pen) + SUM_W'(off));
  endfunction

endpackage

// ----- src/glq_table.sv -----
module glq_table import glq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  glyph_entry_t      wr_entry,
  input  logic              rd_en,
  input  logic              rd_hit,
  input  logic [SLOT_W-1:0] rd_slot,
  output glyph_entry_t      rd_entry,
  output logic              rd_present
);

  glyph_entry_t           glyph_mem_r [GLYPH_SLOTS];
  logic [GLYPH_SLOTS-1:0] present_r;
  glyph_entry_t           rd_entry_r;
  logic                   rd_present_r;

  // Write the metric memory; reads are registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      glyph_mem_r[wr_slot] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r   <= glyph_mem_r[rd_slot];
      rd_present_r <= rd_hit && present_r[rd_slot];
    end
  end

  // Mark slots as loaded; reset empties the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr_en) begin
      present_r[wr_slot] <= 1'b1;
    end
  end

  assign rd_entry   = rd_entry_r;
  assign rd_present = rd_present_r;

endmodule

// ----- src/glq_offset.sv -----
module glq_offset import glq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kind_t              in_kind,
  input  glyph_entry_t       in_entry,
  input  logic [SCALE_W-1:0] scale,
  input  logic               flip_y,
  output logic               out_valid,
  input  logic               out_ready,
  output off_t               out_item
);

  logic                     s2_valid_r;
  kind_t                    s2_kind_r;
  tex_box_t                 s2_tex_r;
  logic signed [PROD_W-1:0] s2_p_xl_r, s2_p_xr_r, s2_p_yt_r, s2_p_yb_r, s2_p_step_r;
  logic                     s2_ready;

  logic                     s3_valid_r;
  off_t                     s3_item_r;
  off_t                     s3_item_nxt;
  logic                     s3_ready;

  logic signed [SCALE_W:0]  scale_s;
  logic signed [EXT_W-1:0]  m_xl, m_xr, m_yt, m_yb, m_step, m_wid, m_hgt;
  logic signed [PROD_W-1:0] p_xl_nxt, p_xr_nxt, p_yt_nxt, p_yb_nxt, p_step_nxt;
  logic signed [OFF_W-1:0]  r_yt, r_yb;

  assign s3_ready  = !s3_valid_r || out_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign in_ready  = s2_ready;
  assign out_valid = s3_valid_r;
  assign out_item  = s3_item_r;

  // Form corner metrics and scale them
  always_comb begin
    scale_s    = $signed({1'b0, scale});
    m_wid      = $signed(EXT_W'(in_entry.wid));
    m_hgt      = $signed(EXT_W'(in_entry.hgt));
    m_xl       = EXT_W'(in_entry.xoff);
    m_xr       = m_xl + m_wid;
    m_yt       = EXT_W'(in_entry.yoff);
    m_yb       = m_yt + m_hgt;
    m_step     = $signed(EXT_W'(in_entry.step));
    p_xl_nxt   = scale_s * m_xl;
    p_xr_nxt   = scale_s * m_xr;
    p_yt_nxt   = scale_s * m_yt;
    p_yb_nxt   = scale_s * m_yb;
    p_step_nxt = scale_s * m_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_kind_r   <= in_kind;
      s2_tex_r    <= in_entry.tex;
      s2_p_xl_r   <= p_xl_nxt;
      s2_p_xr_r   <= p_xr_nxt;
      s2_p_yt_r   <= p_yt_nxt;
      s2_p_yb_r   <= p_yb_nxt;
      s2_p_step_r <= p_step_nxt;
    end
  end

  // Round products to Q.8 and flip the vertical offsets
  always_comb begin
    r_yt               = round_q8(s2_p_yt_r);
    r_yb               = round_q8(s2_p_yb_r);
    s3_item_nxt.kind   = s2_kind_r;
    s3_item_nxt.tex    = s2_tex_r;
    s3_item_nxt.dx_l   = round_q8(s2_p_xl_r);
    s3_item_nxt.dx_r   = round_q8(s2_p_xr_r);
    s3_item_nxt.dy_t   = flip_y ? -r_yt : r_yt;
    s3_item_nxt.dy_b   = flip_y ? -r_yb : r_yb;
    s3_item_nxt.d_step = round_q8(s2_p_step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_item_r <= s3_item_nxt;
    end
  end

endmodule

// ----- src/glq_emit.sv -----
module glq_emit import glq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  off_t                    in_item,
  input  logic signed [POS_W-1:0] origin_x,
  input  logic signed [POS_W-1:0] origin_y,
  input  logic signed [POS_W-1:0] origin_z,
  input  logic [SCALE_W-1:0]      scale,
  input  logic                    flip_y,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [127:0]            out_tdata,
  output logic [1:0]              out_tuser,
  output logic                    out_tlast
);

  logic signed [POS_W-1:0] pen_x_r, pen_x_nxt;
  logic signed [POS_W-1:0] pen_y_r, pen_y_nxt;
  logic signed [SUM_W-1:0] line_step;

  logic                    quad_valid_r;
  corner_t                 corner_r;
  logic signed [POS_W-1:0] xl_r, xr_r, yt_r, yb_r;
  tex_box_t                tex_r;
  logic                    quad_ready;
  logic                    quad_done;
  logic                    take;
  logic                    load_quad;
  logic                    emit;
  logic                    out_free;
  logic                    is_right;
  logic                    is_bottom;

  logic                    out_valid_r;
  logic [127:0]            out_data_r;
  corner_t                 out_corner_r;
  logic                    out_last_r;

  assign out_free   = !out_valid_r || out_tready;
  assign emit       = quad_valid_r && out_free;
  assign quad_done  = emit && (corner_r == CORNER_BL);
  assign quad_ready = !quad_valid_r || quad_done;
  assign in_ready   = (in_item.kind != KIND_GLYPH) || quad_ready;
  assign take       = in_valid && in_ready;
  assign load_quad  = take && (in_item.kind == KIND_GLYPH);

  // Move the pen for each item in order
  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    line_step = flip_y ? -$signed(SUM_W'(scale)) : $signed(SUM_W'(scale));
    if (take) begin
      case (in_item.kind)
        KIND_START: begin
          pen_x_nxt = origin_x;
          pen_y_nxt = origin_y;
        end
        KIND_NEWLINE: begin
          pen_x_nxt = origin_x;
          pen_y_nxt = sat_pos(SUM_W'(pen_y_r) + line_step);
        end
        KIND_ADVANCE, KIND_GLYPH: begin
          pen_x_nxt = add_pos(pen_x_r, in_item.d_step);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

  // Hold the quad corners while its four vertices drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_valid_r <= 1'b0;
      corner_r     <= CORNER_TL;
    end else if (load_quad) begin
      quad_valid_r <= 1'b1;
      corner_r     <= CORNER_TL;
    end else if (emit) begin
      quad_valid_r <= !quad_done;
      corner_r     <= corner_t'(corner_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_quad) begin
      xl_r  <= add_pos(pen_x_r, in_item.dx_l);
      xr_r  <= add_pos(pen_x_r, in_item.dx_r);
      yt_r  <= add_pos(pen_y_r, in_item.dy_t);
      yb_r  <= add_pos(pen_y_r, in_item.dy_b);
      tex_r <= in_item.tex;
    end
  end

  assign is_right  = (corner_r == CORNER_TR) || (corner_r == CORNER_BR);
  assign is_bottom = (corner_r == CORNER_BR) || (corner_r == CORNER_BL);

  // Output register decouples the result side from the quad walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r   <= {is_bottom ? tex_r.bottom : tex_r.top,
                       is_right ? tex_r.right : tex_r.left,
                       origin_z,
                       is_bottom ? yb_r : yt_r,
                       is_right ? xr_r : xl_r};
      out_corner_r <= corner_r;
      out_last_r   <= (corner_r == CORNER_BL);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_corner_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/glyph_quad_layout.sv -----
// Glyph quad layout: turns a stream of load, start and character commands into
// textured quad vertices. Load commands fill a 256-slot glyph metric memory and
// return nothing; start resets the pen to the origin; a character with a loaded
// glyph yields four vertex transactions (top-left, top-right, bottom-right,
// bottom-left, tlast on the fourth), while newline, space and missing glyphs only
// move the pen or do nothing. Every command is one input transfer, at one command
// per cycle while in_tready is high; a glyph then occupies the vertex emitter until
// its four vertices drain, so a following glyph waits while other commands flow on.
// The first vertex of a character passes the memory read at the accepting edge, the
// scale multiply, rounding, pen add and output register in turn. Reset empties the
// glyph table. Configuration writes are taken at any time but belong in idle gaps.
module glyph_quad_layout import glq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Command stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // char_code[7:0], glyph_xoffset[23:8], glyph_yoffset[39:24], glyph_width[55:40],
  // glyph_height[71:56], glyph_advance[87:72], tex_left[103:88], tex_top[119:104],
  // tex_right[135:120], tex_bottom[151:136]
  input  logic [151:0]         in_tdata,
  // command[1:0]
  input  logic [1:0]           in_tuser,
  // Vertex stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // vertex_x[31:0], vertex_y[63:32], vertex_z[95:64], tex_u[111:96], tex_v[127:112]
  output logic [127:0]         out_tdata,
  // corner[1:0]
  output logic [1:0]           out_tuser,
  // last_corner
  output logic                 out_tlast,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic signed [POS_W-1:0] origin_x_r, origin_y_r, origin_z_r;
  logic [SCALE_W-1:0]      scale_r;
  logic                    flip_y_r;

  cmd_t                    in_cmd;
  logic [CODE_W-1:0]       in_code;
  logic signed [15:0]      in_xoff, in_yoff;
  logic                    accept;
  logic                    slot_hit;
  logic [SLOT_W-1:0]       slot;
  glyph_entry_t            wr_entry;
  logic                    wr_en;
  logic                    rd_en;

  logic                    s1_valid_r;
  cmd_t                    s1_cmd_r;
  logic [CODE_W-1:0]       s1_code_r;
  logic                    s1_ready;
  kind_t                   s1_kind;
  glyph_entry_t            rd_entry;
  logic                    rd_present;

  logic                    off_ready;
  logic                    off_valid;
  off_t                    off_item;
  logic                    emit_ready;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      scale_r    <= SCALE_RESET;
      flip_y_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X: origin_x_r <= cfg_data;
        CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        CFG_ORIGIN_Z: origin_z_r <= cfg_data;
        CFG_SCALE:    scale_r    <= cfg_data[SCALE_W-1:0];
        CFG_FLIP_Y:   flip_y_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the command and route loads and lookups to the table
  assign in_cmd   = cmd_t'(in_tuser);
  assign in_code  = in_tdata[7:0];
  assign in_xoff  = in_tdata[23:8];
  assign in_yoff  = in_tdata[39:24];
  assign accept   = in_tvalid && in_tready;
  assign slot_hit = 32'(in_code) < 32'(GLYPH_SLOTS);
  assign slot     = SLOT_W'(in_code);
  assign wr_en    = accept && (in_cmd == CMD_LOAD) && slot_hit;
  assign rd_en    = accept && (in_cmd == CMD_CHAR);

  always_comb begin
    wr_entry.xoff       = METRIC_BITS'(in_xoff);
    wr_entry.yoff       = METRIC_BITS'(in_yoff);
    wr_entry.wid        = METRIC_BITS'(in_tdata[55:40]);
    wr_entry.hgt        = METRIC_BITS'(in_tdata[71:56]);
    wr_entry.step       = METRIC_BITS'(in_tdata[87:72]);
    wr_entry.tex.left   = in_tdata[103:88];
    wr_entry.tex.top    = in_tdata[119:104];
    wr_entry.tex.right  = in_tdata[135:120];
    wr_entry.tex.bottom = in_tdata[151:136];
  end

  glq_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_slot    (slot),
    .wr_entry   (wr_entry),
    .rd_en      (rd_en),
    .rd_hit     (slot_hit),
    .rd_slot    (slot),
    .rd_entry   (rd_entry),
    .rd_present (rd_present)
  );

  // Lookup stage: advance when the scale pipeline takes the item
  assign s1_ready  = !s1_valid_r || off_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_cmd_r  <= in_cmd;
      s1_code_r <= in_code;
    end
  end

  // Classify the item once the table answer is back
  always_comb begin
    s1_kind = KIND_NONE;
    case (s1_cmd_r)
      CMD_START: s1_kind = KIND_START;
      CMD_CHAR: begin
        if (s1_code_r == CODE_NEWLINE) begin
          s1_kind = KIND_NEWLINE;
        end else if (!rd_present) begin
          s1_kind = KIND_NONE;
        end else if (s1_code_r == CODE_SPACE) begin
          s1_kind = KIND_ADVANCE;
        end else begin
          s1_kind = KIND_GLYPH;
        end
      end
      default: s1_kind = KIND_NONE;
    endcase
  end

  glq_offset u_offset (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (off_ready),
    .in_kind   (s1_kind),
    .in_entry  (rd_entry),
    .scale     (scale_r),
    .flip_y    (flip_y_r),
    .out_valid (off_valid),
    .out_ready (emit_ready),
    .out_item  (off_item)
  );

  glq_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (off_valid),
    .in_ready   (emit_ready),
    .in_item    (off_item),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .origin_z   (origin_z_r),
    .scale      (scale_r),
    .flip_y     (flip_y_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/glq_checker.sv -----
`timescale 1ns / 1ps

// Watches the command, vertex and register channels of glyph_quad_layout,
// keeps its own glyph table, pen and register copies, predicts the vertices
// of every accepted command and compares them in order with what comes out.
module glq_checker import glq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [151:0]         in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [127:0]         out_tdata,
  input  logic [1:0]           out_tuser,
  input  logic                 out_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatches,
  output int                   vertices_pending,
  output int                   vertices_checked
);

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam int     MAX_LINES = 40;

  typedef struct {
    bit                 present;
    logic signed [15:0] xoff;
    logic signed [15:0] yoff;
    logic [15:0]        wid;
    logic [15:0]        hgt;
    logic [15:0]        step;
    logic [15:0]        tex_l;
    logic [15:0]        tex_t;
    logic [15:0]        tex_r;
    logic [15:0]        tex_b;
  } glyph_rec_t;

  typedef struct {
    longint  x;
    longint  y;
    longint  z;
    int      u;
    int      v;
    corner_t corner;
    bit      last;
  } vertex_t;

  glyph_rec_t glyph_tbl [GLYPH_SLOTS];
  vertex_t    vertex_q [$];

  // Register copies and pen
  longint org_x, org_y, org_z, font_scale;
  bit     flip;
  longint pen_x, pen_y;

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Q4.12 em metric times Q16.8 scale, rounded half up to Q.8
  function automatic longint scale_em(longint m);
    longint p;
    p = font_scale * m + 64'sd2048;
    return p >>> 12;
  endfunction

  task automatic report(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= MAX_LINES)
      $display("%0t glq mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // Update the table and pen for one command and queue the vertices it makes
  task automatic predict_item(logic [1:0] cmd, logic [151:0] d);
    logic [7:0] code;
    glyph_rec_t g;
    longint     xl, xr, dt, db, yt, yb;
    bit         right, bottom;
    vertex_t    vx;
    corner_t    order [4];
    order = '{CORNER_TL, CORNER_TR, CORNER_BR, CORNER_BL};
    code  = d[7:0];
    case (cmd_t'(cmd))
      CMD_LOAD: begin
        g.present = 1'b1;
        g.xoff    = d[23:8];
        g.yoff    = d[39:24];
        g.wid     = d[55:40];
        g.hgt     = d[71:56];
        g.step    = d[87:72];
        g.tex_l   = d[103:88];
        g.tex_t   = d[119:104];
        g.tex_r   = d[135:120];
        g.tex_b   = d[151:136];
        glyph_tbl[code] = g;
      end
      CMD_START: begin
        pen_x = org_x;
        pen_y = org_y;
      end
      CMD_CHAR: begin
        g = glyph_tbl[code];
        if (code == CODE_NEWLINE) begin
          pen_x = org_x;
          pen_y = clamp_pos(pen_y + (flip ? -font_scale : font_scale));
        end else if (g.present && code == CODE_SPACE) begin
          pen_x = clamp_pos(pen_x + scale_em(longint'(g.step)));
        end else if (g.present) begin
          xl = clamp_pos(pen_x + scale_em(longint'(g.xoff)));
          xr = clamp_pos(pen_x + scale_em(longint'(g.xoff) + longint'(g.wid)));
          dt = scale_em(longint'(g.yoff));
          db = scale_em(longint'(g.yoff) + longint'(g.hgt));
          if (flip) begin
            dt = -dt;
            db = -db;
          end
          yt = clamp_pos(pen_y + dt);
          yb = clamp_pos(pen_y + db);
          foreach (order[k]) begin
            right     = (order[k] == CORNER_TR) || (order[k] == CORNER_BR);
            bottom    = (order[k] == CORNER_BR) || (order[k] == CORNER_BL);
            vx.x      = right ? xr : xl;
            vx.y      = bottom ? yb : yt;
            vx.z      = org_z;
            vx.u      = right ? g.tex_r : g.tex_l;
            vx.v      = bottom ? g.tex_b : g.tex_t;
            vx.corner = order[k];
            vx.last   = (order[k] == CORNER_BL);
            vertex_q  = {vertex_q, vx};
          end
          pen_x = clamp_pos(pen_x + scale_em(longint'(g.step)));
        end
      end
      default: begin
        // unused command: drop
      end
    endcase
  endtask

  // Compare one vertex transaction with the oldest expectation
  task automatic check_vertex();
    vertex_t w;
    longint  gx, gy, gz;
    gx = longint'($signed(out_tdata[31:0]));
    gy = longint'($signed(out_tdata[63:32]));
    gz = longint'($signed(out_tdata[95:64]));
    if (vertex_q.size() == 0) begin
      report("vertex x with no character waiting", gx, 0);
    end else begin
      w = vertex_q.pop_front();
      if (gx != w.x) report("vertex_x", gx, w.x);
      if (gy != w.y) report("vertex_y", gy, w.y);
      if (gz != w.z) report("vertex_z", gz, w.z);
      if (out_tdata[111:96] != w.u) report("tex_u", out_tdata[111:96], w.u);
      if (out_tdata[127:112] != w.v) report("tex_v", out_tdata[127:112], w.v);
      if (out_tuser != w.corner) report("corner", out_tuser, w.corner);
      if (out_tlast != w.last) report("last_corner", out_tlast, w.last);
    end
    vertices_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (glyph_tbl[i]) glyph_tbl[i].present = 1'b0;
      org_x      = 0;
      org_y      = 0;
      org_z      = 0;
      font_scale = longint'(SCALE_RESET);
      flip       = 1'b0;
      pen_x      = 0;
      pen_y      = 0;
      vertex_q.delete();
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ORIGIN_X: org_x = longint'($signed(cfg_data));
          CFG_ORIGIN_Y: org_y = longint'($signed(cfg_data));
          CFG_ORIGIN_Z: org_z = longint'($signed(cfg_data));
          CFG_SCALE:    font_scale = longint'(cfg_data[SCALE_W-1:0]);
          CFG_FLIP_Y:   flip = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_vertex();
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
    end
    vertices_pending <= vertex_q.size();
  end

endmodule

// ----- tb/tb_glyph_quad_layout.sv -----
`timescale 1ns / 1ps

module tb_glyph_quad_layout;
  import glq_pkg::*;

  localparam int SETTLE_CYCLES = 12;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [151:0]         in_tdata   = '0;
  logic [1:0]           in_tuser   = CMD_NOP;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [127:0]         out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_ORIGIN_X;
  logic [31:0]          cfg_data   = '0;

  int mismatches;
  int vertices_pending;
  int vertices_checked;

  int idle_pct  = 0;
  int stall_pct = 0;
  int cmds_sent = 0;
  int cfg_writes = 0;

  bit         slot_loaded [256];
  logic [7:0] loaded_codes [$];

  glyph_quad_layout u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  glq_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .vertices_pending (vertices_pending),
    .vertices_checked (vertices_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Vertex sink: stall at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [143:0] noise_fields();
    return {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
  endfunction

  // Present one command transaction, idling first at random
  task automatic send_item(cmd_t cmd, logic [151:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_NOP) cmds_sent++;
  endtask

  task automatic send_char(logic [7:0] code);
    send_item(CMD_CHAR, {noise_fields(), code});
  endtask

  task automatic send_start();
    send_item(CMD_START, {noise_fields(), 8'($urandom())});
  endtask

  task automatic load_glyph(logic [7:0] code, logic [15:0] xo, logic [15:0] yo,
                            logic [15:0] wd, logic [15:0] ht, logic [15:0] adv,
                            logic [15:0] tl, logic [15:0] tt, logic [15:0] tr,
                            logic [15:0] tbm);
    if (!slot_loaded[code]) begin
      slot_loaded[code] = 1'b1;
      loaded_codes = {loaded_codes, code};
    end
    send_item(CMD_LOAD, {tbm, tr, tt, tl, adv, ht, wd, yo, xo, code});
  endtask

  task automatic load_random(logic [7:0] code);
    load_glyph(code, 16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
               16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
               16'($urandom()));
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [23:0] sc, logic fl);
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_ORIGIN_Z, oz);
    cfg_write(CFG_SCALE, {8'd0, sc});
    cfg_write(CFG_FLIP_Y, {31'd0, fl});
  endtask

  // Drop valid, wait for every vertex, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_setting(int s);
    case (s)
      0: set_config($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom(),
                    24'(SCALE_RESET), 1'b0);
      1: set_config(32'h7FFF_FFFF, 32'h8000_0000, $urandom(), 24'd0, 1'b1);
      2: set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0);
      default: set_config($urandom(), $urandom(), $urandom(),
                          24'($urandom_range(1, 4096)), 1'b1);
    endcase
  endtask

  // Mostly text over the loaded alphabet, with loads, starts, line breaks and noise
  task automatic random_text(int n);
    int         target;
    int         sel;
    logic [7:0] code;
    target = cmds_sent + n;
    while (cmds_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(32, 96));
        load_random(code);
      end else if (sel < 18) begin
        send_start();
      end else if (sel < 23) begin
        send_char(CODE_NEWLINE);
      end else if (sel < 30) begin
        send_char(CODE_SPACE);
      end else if (sel < 95) begin
        if (loaded_codes.size() != 0 && $urandom_range(0, 99) < 85)
          code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
        else
          code = 8'($urandom_range(0, 255));
        send_char(code);
      end else begin
        send_item(CMD_NOP, {noise_fields(), 8'($urandom())});
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: missing glyph, space before loading, bare newline
    send_char(8'd65);
    send_char(CODE_SPACE);
    send_char(CODE_NEWLINE);
    // Field extremes, both polarities
    load_glyph(8'd65, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    load_glyph(8'd66, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
               16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    load_glyph(CODE_SPACE, 16'h1234, 16'hF000, 16'h0800, 16'h0800, 16'h1000,
               16'h0100, 16'h0200, 16'h0300, 16'h0400);
    // A glyph at the newline slot must not turn newline into a glyph
    load_random(CODE_NEWLINE);
    load_random(8'd0);
    load_random(8'd255);
    send_start();
    send_char(8'd65);
    send_char(8'd66);
    send_char(CODE_SPACE);
    send_char(CODE_NEWLINE);
    send_char(8'd0);
    send_char(8'd255);
    send_item(CMD_NOP, {noise_fields(), 8'd65});
    send_char(8'd200);
    settle();

    // Saturation corner: huge scale, flipped, origin at the range edges
    set_config(32'h7FFF_FF00, 32'h8000_0000, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
    send_start();
    send_char(8'd65);
    send_char(CODE_NEWLINE);
    send_char(8'd66);
    send_char(8'd65);
    send_start();
    settle();

    // Random text under four idle mixes and four register settings
    for (int r = 0; r < 8; r++) begin
      case (r / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      pick_setting(r % 4);
      random_text(62);
      settle();
    end

    $display("glq: %0d commands, %0d vertices checked, %0d register writes",
             cmds_sent, vertices_checked, cfg_writes);
    $display("glq: covered table edges, saturation, flip, and four idle/stall mixes");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
